FILE: hw/rtl/pfi_pkg.sv
package pfi_pkg;

   localparam int unsigned NUM_PARTICLES_DEF = 256;
   localparam logic [16:0] DAMP_RESET = 17'd7864;
   localparam logic [16:0] Q_ONE = 17'd65536;

   // Command codes carried in req_type.
   localparam logic [3:0] REQ_SET_INIT     = 4'd0;
   localparam logic [3:0] REQ_CLR_FORCE    = 4'd1;
   localparam logic [3:0] REQ_ADD_FORCE    = 4'd2;
   localparam logic [3:0] REQ_REPEL_PT     = 4'd3;
   localparam logic [3:0] REQ_ATTRACT_PT   = 4'd4;
   localparam logic [3:0] REQ_REPEL_PAIR   = 4'd5;
   localparam logic [3:0] REQ_ATTRACT_PAIR = 4'd6;
   localparam logic [3:0] REQ_DAMP         = 4'd7;
   localparam logic [3:0] REQ_UPDATE       = 4'd8;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
   } particle_type;

   typedef struct packed {
      logic [3:0]         req_type;
      logic [7:0]         particle_a;
      logic [7:0]         particle_b;
      logic signed [31:0] arg_x;
      logic signed [31:0] arg_y;
      logic signed [31:0] arg_vx;
      logic signed [31:0] arg_vy;
      logic [30:0]        radius;
      logic signed [31:0] scale;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               in_range;
   } rsp_payload_type;

   typedef enum logic [5:0] {
      ST_CLEAR, ST_IDLE, ST_RDA, ST_LDA, ST_RDB, ST_LDB, ST_SIMPLE,
      ST_UPV, ST_UPP, ST_DMX, ST_DTX, ST_DSX, ST_DMY, ST_DTY, ST_DSY,
      ST_DIFF, ST_SQX, ST_SQY, ST_SQSUM, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_RANGE, ST_RSEL, ST_PCT_GO, ST_PCT_WAIT, ST_PCT_LD,
      ST_UX_GO, ST_UX_WAIT, ST_UX_LD, ST_UY_GO, ST_UY_WAIT, ST_UY_LD,
      ST_MXS, ST_TX, ST_MXP, ST_FX, ST_MYS, ST_TY, ST_MYP, ST_FY,
      ST_APPLY, ST_WRA, ST_WRB, ST_RESP
   } ctrl_state_type;

   typedef enum logic [5:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_RD_A, OP_LD_A, OP_RD_B, OP_LD_B,
      OP_SIMPLE, OP_UPD_V, OP_UPD_P, OP_MUL_VXD, OP_MUL_VYD, OP_TRUNC,
      OP_DAMP_X, OP_DAMP_Y, OP_DIFF, OP_MUL_DX, OP_MUL_DY, OP_SQ_SUM,
      OP_SQRT_GO, OP_RANGE, OP_PCT_GO, OP_PCT_LD, OP_UX_GO, OP_UX_LD,
      OP_UY_GO, OP_UY_LD, OP_MUL_UXS, OP_MUL_UYS, OP_MUL_TP, OP_F_X,
      OP_F_Y, OP_APPLY, OP_WR_A, OP_WR_B, OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic       hit;
      logic       radius_zero;
      logic       sqrt_done;
      logic       div_done;
      logic       clr_last;
      logic       rsp_free;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh07FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (v < $signed(34'h380000000)) begin
         return $signed(32'h80000000);
      end
      return v[31:0];
   endfunction

   // Divide by 65536 with rounding toward zero.
   function automatic logic signed [67:0] trunc16(input logic signed [67:0] p);
      logic signed [67:0] adj;
      adj = p + (p[67] ? 68'sd65535 : 68'sd0);
      return adj >>> 16;
   endfunction

endpackage

FILE: hw/rtl/pfi_if.sv
interface pfi_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         req_type;
   logic [7:0]         particle_a;
   logic [7:0]         particle_b;
   logic signed [31:0] arg_x;
   logic signed [31:0] arg_y;
   logic signed [31:0] arg_vx;
   logic signed [31:0] arg_vy;
   logic [30:0]        radius;
   logic signed [31:0] scale;
   modport source(output valid, req_type, particle_a, particle_b, arg_x, arg_y,
                  arg_vx, arg_vy, radius, scale, input ready);
   modport sink(input valid, req_type, particle_a, particle_b, arg_x, arg_y,
                arg_vx, arg_vy, radius, scale, output ready);
endinterface

interface pfi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic               in_range;
   modport source(output valid, pos_x, pos_y, vel_x, vel_y, in_range, input ready);
   modport sink(input valid, pos_x, pos_y, vel_x, vel_y, in_range, output ready);
endinterface

interface pfi_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] damping_coeff;
   modport source(output valid, damping_coeff, input ready);
   modport sink(input valid, damping_coeff, output ready);
endinterface

FILE: hw/rtl/pfi_sqrt.sv
module pfi_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, res_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [63:0] sum;

   assign sum = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_ff   <= v_ff - sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

FILE: hw/rtl/pfi_div.sv
module pfi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [16:0] quo
);

   // Quotients here never exceed 65536, so only 17 quotient bits are formed.
   logic [32:0] rem_ff;
   logic [16:0] lo_ff, q_ff;
   logic [31:0] den_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] r2;
   logic        qb;

   always_comb begin
      r2 = {rem_ff[31:0], lo_ff[16]};
      qb = (r2 >= {1'b0, den_ff});
      if (qb) begin
         r2 = r2 - {1'b0, den_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd16) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {2'b00, num[47:17]};
         lo_ff  <= num[16:0];
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= r2;
         lo_ff  <= {lo_ff[15:0], 1'b0};
         q_ff   <= {q_ff[15:0], qb};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

FILE: hw/rtl/pfi_dp.sv
module pfi_dp #(
   parameter int unsigned NUM_PARTICLES = pfi_pkg::NUM_PARTICLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pfi_pkg::dp_cmd_type      cmd,
   output pfi_pkg::dp_status_type   status,
   input  pfi_pkg::req_payload_type req_data,
   input  logic                     csr_we,
   input  logic [16:0]              csr_data,
   output pfi_pkg::rsp_payload_type rsp_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready
);

   localparam int unsigned IDX_W = $clog2(NUM_PARTICLES);

   pfi_pkg::particle_type part_mem [NUM_PARTICLES];
   pfi_pkg::particle_type rd_data_ff, pa_ff, pb_ff, wr_data;
   logic [IDX_W-1:0]   ia_ff, ib_ff, clr_ff, rd_addr, wr_addr;
   logic               mem_we;
   logic [3:0]         type_ff;
   logic signed [31:0] ax_ff, ay_ff, avx_ff, avy_ff, scale_ff;
   logic [30:0]        rad_ff;
   logic [16:0]        damp_ff, pct_ff;
   logic signed [67:0] prod_ff, mul_p, tr;
   logic signed [33:0] mul_a, mul_b, t_ff, fxv_ff, fyv_ff, dlt_x, dlt_y;
   logic [63:0]        sqx_ff, sq_ff;
   logic [31:0]        len_ff, dx_mag, dy_mag, len_diff;
   logic signed [31:0] dx_ff, dy_ff, src_x, src_y;
   logic signed [17:0] ux_ff, uy_ff;
   logic               hit_ff, rsp_valid_ff, is_pair, is_attract;
   pfi_pkg::rsp_payload_type rsp_ff;
   logic               sqrt_done, div_done, div_start;
   logic [31:0]        root;
   logic [16:0]        quo;
   logic [47:0]        div_num;
   logic [31:0]        div_den;

   function automatic logic [IDX_W-1:0] idx_mod(input logic [7:0] v);
      logic [16:0] rem;
      rem = '0;
      for (int i = 7; i >= 0; i--) begin
         rem = {rem[15:0], v[i]};
         if (rem >= 17'(NUM_PARTICLES)) begin
            rem = rem - 17'(NUM_PARTICLES);
         end
      end
      return rem[IDX_W-1:0];
   endfunction

   function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   assign is_pair = (type_ff == pfi_pkg::REQ_REPEL_PAIR) ||
                    (type_ff == pfi_pkg::REQ_ATTRACT_PAIR);
   assign is_attract = (type_ff == pfi_pkg::REQ_ATTRACT_PT) ||
                       (type_ff == pfi_pkg::REQ_ATTRACT_PAIR);

   // Particle memory, one read and one write port.
   assign rd_addr = (cmd.op == pfi_pkg::OP_RD_B) ? ib_ff : ia_ff;
   always_comb begin
      mem_we  = 1'b0;
      wr_addr = ia_ff;
      wr_data = pa_ff;
      case (cmd.op)
         pfi_pkg::OP_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         pfi_pkg::OP_WR_A: mem_we = 1'b1;
         pfi_pkg::OP_WR_B: begin
            mem_we  = 1'b1;
            wr_addr = ib_ff;
            wr_data = pb_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         part_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= part_mem[rd_addr];
   end

   // Shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         pfi_pkg::OP_MUL_DX: begin
            mul_a = ext34(dx_ff);
            mul_b = ext34(dx_ff);
         end
         pfi_pkg::OP_MUL_DY: begin
            mul_a = ext34(dy_ff);
            mul_b = ext34(dy_ff);
         end
         pfi_pkg::OP_MUL_VXD: begin
            mul_a = ext34(pa_ff.vx);
            mul_b = {17'b0, damp_ff};
         end
         pfi_pkg::OP_MUL_VYD: begin
            mul_a = ext34(pa_ff.vy);
            mul_b = {17'b0, damp_ff};
         end
         pfi_pkg::OP_MUL_UXS: begin
            mul_a = {{16{ux_ff[17]}}, ux_ff};
            mul_b = ext34(scale_ff);
         end
         pfi_pkg::OP_MUL_UYS: begin
            mul_a = {{16{uy_ff[17]}}, uy_ff};
            mul_b = ext34(scale_ff);
         end
         pfi_pkg::OP_MUL_TP: begin
            mul_a = t_ff;
            mul_b = {17'b0, pct_ff};
         end
         default: mul_a = '0;
      endcase
   end
   assign mul_p = mul_a * mul_b;
   assign tr    = pfi_pkg::trunc16(prod_ff);

   // Shared divider inputs.
   assign dx_mag   = dx_ff[31] ? 32'(-dx_ff) : dx_ff;
   assign dy_mag   = dy_ff[31] ? 32'(-dy_ff) : dy_ff;
   assign len_diff = {1'b0, rad_ff} - len_ff;
   assign div_start = (cmd.op == pfi_pkg::OP_PCT_GO) || (cmd.op == pfi_pkg::OP_UX_GO) ||
                      (cmd.op == pfi_pkg::OP_UY_GO);
   always_comb begin
      div_num = {dy_mag, 16'b0};
      div_den = len_ff;
      case (cmd.op)
         pfi_pkg::OP_PCT_GO: begin
            div_num = {len_diff, 16'b0};
            div_den = {1'b0, rad_ff};
         end
         pfi_pkg::OP_UX_GO: div_num = {dx_mag, 16'b0};
         default: div_num = {dy_mag, 16'b0};
      endcase
   end

   pfi_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == pfi_pkg::OP_SQRT_GO),
      .value (sq_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   pfi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   assign src_x = is_pair ? pb_ff.px : ax_ff;
   assign src_y = is_pair ? pb_ff.py : ay_ff;
   assign dlt_x = is_attract ? -fxv_ff : fxv_ff;
   assign dlt_y = is_attract ? -fyv_ff : fyv_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         damp_ff      <= pfi_pkg::DAMP_RESET;
      end else begin
         if (cmd.op == pfi_pkg::OP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.op == pfi_pkg::OP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            damp_ff <= csr_data;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         pfi_pkg::OP_LOAD: begin
            type_ff  <= req_data.req_type;
            ia_ff    <= idx_mod(req_data.particle_a);
            ib_ff    <= idx_mod(req_data.particle_b);
            ax_ff    <= req_data.arg_x;
            ay_ff    <= req_data.arg_y;
            avx_ff   <= req_data.arg_vx;
            avy_ff   <= req_data.arg_vy;
            rad_ff   <= req_data.radius;
            scale_ff <= req_data.scale;
            hit_ff   <= 1'b0;
         end
         pfi_pkg::OP_LD_A: pa_ff <= rd_data_ff;
         pfi_pkg::OP_LD_B: pb_ff <= rd_data_ff;
         pfi_pkg::OP_SIMPLE: begin
            case (type_ff)
               pfi_pkg::REQ_SET_INIT: begin
                  pa_ff.px <= ax_ff;
                  pa_ff.py <= ay_ff;
                  pa_ff.vx <= avx_ff;
                  pa_ff.vy <= avy_ff;
               end
               pfi_pkg::REQ_CLR_FORCE: begin
                  pa_ff.fx <= '0;
                  pa_ff.fy <= '0;
               end
               pfi_pkg::REQ_ADD_FORCE: begin
                  pa_ff.fx <= pfi_pkg::sat32(ext34(pa_ff.fx) + ext34(ax_ff));
                  pa_ff.fy <= pfi_pkg::sat32(ext34(pa_ff.fy) + ext34(ay_ff));
               end
               default: pa_ff <= pa_ff;
            endcase
         end
         pfi_pkg::OP_UPD_V: begin
            pa_ff.vx <= pfi_pkg::sat32(ext34(pa_ff.vx) + ext34(pa_ff.fx));
            pa_ff.vy <= pfi_pkg::sat32(ext34(pa_ff.vy) + ext34(pa_ff.fy));
         end
         pfi_pkg::OP_UPD_P: begin
            pa_ff.px <= pfi_pkg::sat32(ext34(pa_ff.px) + ext34(pa_ff.vx));
            pa_ff.py <= pfi_pkg::sat32(ext34(pa_ff.py) + ext34(pa_ff.vy));
         end
         pfi_pkg::OP_MUL_VXD, pfi_pkg::OP_MUL_VYD, pfi_pkg::OP_MUL_UXS,
         pfi_pkg::OP_MUL_UYS, pfi_pkg::OP_MUL_TP, pfi_pkg::OP_MUL_DX: prod_ff <= mul_p;
         pfi_pkg::OP_MUL_DY: begin
            prod_ff <= mul_p;
            sqx_ff  <= prod_ff[63:0];
         end
         pfi_pkg::OP_SQ_SUM: sq_ff <= sqx_ff + prod_ff[63:0];
         pfi_pkg::OP_TRUNC: t_ff <= tr[33:0];
         pfi_pkg::OP_DAMP_X: pa_ff.fx <= pfi_pkg::sat32(ext34(pa_ff.fx) - t_ff);
         pfi_pkg::OP_DAMP_Y: pa_ff.fy <= pfi_pkg::sat32(ext34(pa_ff.fy) - t_ff);
         pfi_pkg::OP_DIFF: begin
            dx_ff <= pfi_pkg::sat32(ext34(pa_ff.px) - ext34(src_x));
            dy_ff <= pfi_pkg::sat32(ext34(pa_ff.py) - ext34(src_y));
         end
         pfi_pkg::OP_RANGE: begin
            len_ff <= root;
            pct_ff <= pfi_pkg::Q_ONE;
            hit_ff <= (root != '0) && ((rad_ff == '0) || (root <= {1'b0, rad_ff}));
         end
         pfi_pkg::OP_PCT_LD: pct_ff <= quo;
         pfi_pkg::OP_UX_LD: ux_ff <= dx_ff[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
         pfi_pkg::OP_UY_LD: uy_ff <= dy_ff[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
         pfi_pkg::OP_F_X: fxv_ff <= tr[33:0];
         pfi_pkg::OP_F_Y: fyv_ff <= tr[33:0];
         pfi_pkg::OP_APPLY: begin
            pa_ff.fx <= pfi_pkg::sat32(ext34(pa_ff.fx) + dlt_x);
            pa_ff.fy <= pfi_pkg::sat32(ext34(pa_ff.fy) + dlt_y);
            pb_ff.fx <= pfi_pkg::sat32(ext34(pb_ff.fx) - dlt_x);
            pb_ff.fy <= pfi_pkg::sat32(ext34(pb_ff.fy) - dlt_y);
         end
         pfi_pkg::OP_RESP: begin
            rsp_ff.pos_x    <= pa_ff.px;
            rsp_ff.pos_y    <= pa_ff.py;
            rsp_ff.vel_x    <= pa_ff.vx;
            rsp_ff.vel_y    <= pa_ff.vy;
            rsp_ff.in_range <= hit_ff;
         end
         default: prod_ff <= prod_ff;
      endcase
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.req_type    = type_ff;
   assign status.hit         = hit_ff;
   assign status.radius_zero = (rad_ff == '0);
   assign status.sqrt_done   = sqrt_done;
   assign status.div_done    = div_done;
   assign status.clr_last    = (clr_ff == IDX_W'(NUM_PARTICLES - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule

FILE: hw/rtl/pfi_ctrl.sv
module pfi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pfi_pkg::dp_status_type status,
   output pfi_pkg::dp_cmd_type    cmd
);

   pfi_pkg::ctrl_state_type state_ff, state_in;
   logic is_pair;

   assign is_pair = (status.req_type == pfi_pkg::REQ_REPEL_PAIR) ||
                    (status.req_type == pfi_pkg::REQ_ATTRACT_PAIR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfi_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfi_pkg::ST_CLEAR: if (status.clr_last) state_in = pfi_pkg::ST_IDLE;
         pfi_pkg::ST_IDLE:  if (req_valid) state_in = pfi_pkg::ST_RDA;
         pfi_pkg::ST_RDA:   state_in = pfi_pkg::ST_LDA;
         pfi_pkg::ST_LDA: begin
            if (is_pair) begin
               state_in = pfi_pkg::ST_RDB;
            end else if (status.req_type == pfi_pkg::REQ_REPEL_PT ||
                         status.req_type == pfi_pkg::REQ_ATTRACT_PT) begin
               state_in = pfi_pkg::ST_DIFF;
            end else if (status.req_type == pfi_pkg::REQ_DAMP) begin
               state_in = pfi_pkg::ST_DMX;
            end else if (status.req_type == pfi_pkg::REQ_UPDATE) begin
               state_in = pfi_pkg::ST_UPV;
            end else begin
               state_in = pfi_pkg::ST_SIMPLE;
            end
         end
         pfi_pkg::ST_RDB:    state_in = pfi_pkg::ST_LDB;
         pfi_pkg::ST_LDB:    state_in = pfi_pkg::ST_DIFF;
         pfi_pkg::ST_SIMPLE: state_in = pfi_pkg::ST_WRA;
         pfi_pkg::ST_UPV:    state_in = pfi_pkg::ST_UPP;
         pfi_pkg::ST_UPP:    state_in = pfi_pkg::ST_WRA;
         pfi_pkg::ST_DMX:    state_in = pfi_pkg::ST_DTX;
         pfi_pkg::ST_DTX:    state_in = pfi_pkg::ST_DSX;
         pfi_pkg::ST_DSX:    state_in = pfi_pkg::ST_DMY;
         pfi_pkg::ST_DMY:    state_in = pfi_pkg::ST_DTY;
         pfi_pkg::ST_DTY:    state_in = pfi_pkg::ST_DSY;
         pfi_pkg::ST_DSY:    state_in = pfi_pkg::ST_WRA;
         pfi_pkg::ST_DIFF:   state_in = pfi_pkg::ST_SQX;
         pfi_pkg::ST_SQX:    state_in = pfi_pkg::ST_SQY;
         pfi_pkg::ST_SQY:    state_in = pfi_pkg::ST_SQSUM;
         pfi_pkg::ST_SQSUM:  state_in = pfi_pkg::ST_SQRT_GO;
         pfi_pkg::ST_SQRT_GO: state_in = pfi_pkg::ST_SQRT_WAIT;
         pfi_pkg::ST_SQRT_WAIT: if (status.sqrt_done) state_in = pfi_pkg::ST_RANGE;
         pfi_pkg::ST_RANGE:  state_in = pfi_pkg::ST_RSEL;
         pfi_pkg::ST_RSEL: begin
            if (!status.hit) begin
               state_in = pfi_pkg::ST_WRA;
            end else if (status.radius_zero) begin
               state_in = pfi_pkg::ST_UX_GO;
            end else begin
               state_in = pfi_pkg::ST_PCT_GO;
            end
         end
         pfi_pkg::ST_PCT_GO:   state_in = pfi_pkg::ST_PCT_WAIT;
         pfi_pkg::ST_PCT_WAIT: if (status.div_done) state_in = pfi_pkg::ST_PCT_LD;
         pfi_pkg::ST_PCT_LD:   state_in = pfi_pkg::ST_UX_GO;
         pfi_pkg::ST_UX_GO:    state_in = pfi_pkg::ST_UX_WAIT;
         pfi_pkg::ST_UX_WAIT:  if (status.div_done) state_in = pfi_pkg::ST_UX_LD;
         pfi_pkg::ST_UX_LD:    state_in = pfi_pkg::ST_UY_GO;
         pfi_pkg::ST_UY_GO:    state_in = pfi_pkg::ST_UY_WAIT;
         pfi_pkg::ST_UY_WAIT:  if (status.div_done) state_in = pfi_pkg::ST_UY_LD;
         pfi_pkg::ST_UY_LD:    state_in = pfi_pkg::ST_MXS;
         pfi_pkg::ST_MXS:   state_in = pfi_pkg::ST_TX;
         pfi_pkg::ST_TX:    state_in = pfi_pkg::ST_MXP;
         pfi_pkg::ST_MXP:   state_in = pfi_pkg::ST_FX;
         pfi_pkg::ST_FX:    state_in = pfi_pkg::ST_MYS;
         pfi_pkg::ST_MYS:   state_in = pfi_pkg::ST_TY;
         pfi_pkg::ST_TY:    state_in = pfi_pkg::ST_MYP;
         pfi_pkg::ST_MYP:   state_in = pfi_pkg::ST_FY;
         pfi_pkg::ST_FY:    state_in = pfi_pkg::ST_APPLY;
         pfi_pkg::ST_APPLY: state_in = pfi_pkg::ST_WRA;
         pfi_pkg::ST_WRA:   state_in = (is_pair && status.hit) ? pfi_pkg::ST_WRB
                                                               : pfi_pkg::ST_RESP;
         pfi_pkg::ST_WRB:   state_in = pfi_pkg::ST_RESP;
         pfi_pkg::ST_RESP:  if (status.rsp_free) state_in = pfi_pkg::ST_IDLE;
         default:           state_in = pfi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = pfi_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         pfi_pkg::ST_CLEAR: cmd.op = pfi_pkg::OP_CLEAR;
         pfi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = pfi_pkg::OP_LOAD;
         end
         pfi_pkg::ST_RDA:    cmd.op = pfi_pkg::OP_RD_A;
         pfi_pkg::ST_LDA:    cmd.op = pfi_pkg::OP_LD_A;
         pfi_pkg::ST_RDB:    cmd.op = pfi_pkg::OP_RD_B;
         pfi_pkg::ST_LDB:    cmd.op = pfi_pkg::OP_LD_B;
         pfi_pkg::ST_SIMPLE: cmd.op = pfi_pkg::OP_SIMPLE;
         pfi_pkg::ST_UPV:    cmd.op = pfi_pkg::OP_UPD_V;
         pfi_pkg::ST_UPP:    cmd.op = pfi_pkg::OP_UPD_P;
         pfi_pkg::ST_DMX:    cmd.op = pfi_pkg::OP_MUL_VXD;
         pfi_pkg::ST_DTX, pfi_pkg::ST_DTY, pfi_pkg::ST_TX, pfi_pkg::ST_TY:
            cmd.op = pfi_pkg::OP_TRUNC;
         pfi_pkg::ST_DSX:    cmd.op = pfi_pkg::OP_DAMP_X;
         pfi_pkg::ST_DMY:    cmd.op = pfi_pkg::OP_MUL_VYD;
         pfi_pkg::ST_DSY:    cmd.op = pfi_pkg::OP_DAMP_Y;
         pfi_pkg::ST_DIFF:   cmd.op = pfi_pkg::OP_DIFF;
         pfi_pkg::ST_SQX:    cmd.op = pfi_pkg::OP_MUL_DX;
         pfi_pkg::ST_SQY:    cmd.op = pfi_pkg::OP_MUL_DY;
         pfi_pkg::ST_SQSUM:  cmd.op = pfi_pkg::OP_SQ_SUM;
         pfi_pkg::ST_SQRT_GO: cmd.op = pfi_pkg::OP_SQRT_GO;
         pfi_pkg::ST_RANGE:  cmd.op = pfi_pkg::OP_RANGE;
         pfi_pkg::ST_PCT_GO: cmd.op = pfi_pkg::OP_PCT_GO;
         pfi_pkg::ST_PCT_LD: cmd.op = pfi_pkg::OP_PCT_LD;
         pfi_pkg::ST_UX_GO:  cmd.op = pfi_pkg::OP_UX_GO;
         pfi_pkg::ST_UX_LD:  cmd.op = pfi_pkg::OP_UX_LD;
         pfi_pkg::ST_UY_GO:  cmd.op = pfi_pkg::OP_UY_GO;
         pfi_pkg::ST_UY_LD:  cmd.op = pfi_pkg::OP_UY_LD;
         pfi_pkg::ST_MXS:    cmd.op = pfi_pkg::OP_MUL_UXS;
         pfi_pkg::ST_MYS:    cmd.op = pfi_pkg::OP_MUL_UYS;
         pfi_pkg::ST_MXP, pfi_pkg::ST_MYP: cmd.op = pfi_pkg::OP_MUL_TP;
         pfi_pkg::ST_FX:     cmd.op = pfi_pkg::OP_F_X;
         pfi_pkg::ST_FY:     cmd.op = pfi_pkg::OP_F_Y;
         pfi_pkg::ST_APPLY:  cmd.op = pfi_pkg::OP_APPLY;
         pfi_pkg::ST_WRA:    cmd.op = pfi_pkg::OP_WR_A;
         pfi_pkg::ST_WRB:    cmd.op = pfi_pkg::OP_WR_B;
         pfi_pkg::ST_RESP:   if (status.rsp_free) cmd.op = pfi_pkg::OP_RESP;
         default:            cmd.op = pfi_pkg::OP_NONE;
      endcase
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfi_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_sqrt_wait_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfi_pkg::ST_SQRT_WAIT) |->
      ($past(state_ff) == pfi_pkg::ST_SQRT_GO || $past(state_ff) == pfi_pkg::ST_SQRT_WAIT))
      else $error("square root wait entered without a start");

   a_wrb_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfi_pkg::ST_WRB) |-> (status.hit && is_pair))
      else $error("partner written without an applied pair force");

endmodule

FILE: hw/rtl/particle_force_integrator_top.sv
// Commands: set, clear force, add force and unknown commands read particle a, apply the
// change (none for an unknown code) and write it back; damping and update do the same with
// their own arithmetic. A radial command finds the distance with a 32-step root and, when in
// range, up to three 17-step divisions, all sharing one root unit and one divider.
// Throughput: one item at a time; the next item is taken in the cycle after a result is queued.
// Reset: synchronous, active high; afterwards a clearing pass zeroes every particle entry
// before the first item is accepted. The damping register returns to 7864.
module particle_force_integrator_top #(
   parameter int unsigned NUM_PARTICLES = pfi_pkg::NUM_PARTICLES_DEF
) (
   input logic       clock,
   input logic       reset,
   pfi_req_if.sink   req_ch,
   pfi_rsp_if.source rsp_ch,
   pfi_csr_if.sink   csr_ch
);

   // The controller sequences each command as a series of datapath operations. The
   // datapath owns the particle memory (one 192-bit word per particle), a shared
   // multiplier, an iterative square root and an iterative divider.
   pfi_pkg::dp_cmd_type      cmd;
   pfi_pkg::dp_status_type   status;
   pfi_pkg::req_payload_type req_data;
   pfi_pkg::rsp_payload_type rsp_data;
   logic                     rsp_valid;

   assign req_data.req_type   = req_ch.req_type;
   assign req_data.particle_a = req_ch.particle_a;
   assign req_data.particle_b = req_ch.particle_b;
   assign req_data.arg_x      = req_ch.arg_x;
   assign req_data.arg_y      = req_ch.arg_y;
   assign req_data.arg_vx     = req_ch.arg_vx;
   assign req_data.arg_vy     = req_ch.arg_vy;
   assign req_data.radius     = req_ch.radius;
   assign req_data.scale      = req_ch.scale;

   // Configuration writes are taken unchecked; the user keeps them to when the block is idle.
   assign csr_ch.ready = 1'b1;

   pfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfi_dp #(
      .NUM_PARTICLES (NUM_PARTICLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_ch.valid),
      .csr_data  (csr_ch.damping_coeff),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready)
   );

   // The result register holds one item until the sink takes it.
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.pos_x    = rsp_data.pos_x;
   assign rsp_ch.pos_y    = rsp_data.pos_y;
   assign rsp_ch.vel_x    = rsp_data.vel_x;
   assign rsp_ch.vel_y    = rsp_data.vel_y;
   assign rsp_ch.in_range = rsp_data.in_range;

endmodule

FILE: tb/tb_channels.sv
`timescale 1ns / 1ps

// Test-side channel bundles are the block's own interfaces (pfi_req_if, pfi_rsp_if,
// pfi_csr_if); this file only gathers one small shared test type.
package tb_types_pkg;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               in_range;
   } particle_state_type;
endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int NPART = 256;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 200;
   // Command codes with no meaning; the block must leave the state alone.
   localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

   logic clock;
   logic reset;

   pfi_req_if req_ch();
   pfi_rsp_if rsp_ch();
   pfi_csr_if csr_ch();

   particle_force_integrator_top DUT (
      .clock(clock), .reset(reset),
      .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   int mismatch_count = 0;

   // Prints one line per wrong field and keeps the running count.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Shadow of the particle table and the damping register, plus the queue of
   // particle states the block still owes us.
   class particle_scoreboard;
      logic signed [31:0] px[NPART], py[NPART], vx[NPART], vy[NPART];
      logic signed [31:0] fx[NPART], fy[NPART];
      logic [16:0] damping;
      tb_types_pkg::particle_state_type owed[$];

      function new();
         for (int i = 0; i < NPART; i++) begin
            px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; fx[i] = 0; fy[i] = 0;
         end
         damping = pfi_pkg::DAMP_RESET;
      endfunction

      function logic signed [31:0] clamp(input longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return $signed(32'h80000000);
         return v[31:0];
      endfunction

      function longint unsigned root(input longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Radial push on particle a away from (sx, sy); returns 0 when no force applies.
      function bit radial_push(input int a, input longint sx, input longint sy,
                               input longint rad, input longint scl,
                               output longint ofx, output longint ofy);
         longint dx, dy, ux, uy, pct;
         longint unsigned len;
         dx = clamp(longint'(px[a]) - sx);
         dy = clamp(longint'(py[a]) - sy);
         len = root(longint'(dx * dx) + longint'(dy * dy));
         pct = 65536;
         ofx = 0;
         ofy = 0;
         if (len == 0) return 0;
         if (rad != 0) begin
            if (len > rad) return 0;
            pct = ((rad - longint'(len)) <<< 16) / rad;
         end
         ux = (dx * 65536) / longint'(len);
         uy = (dy * 65536) / longint'(len);
         ofx = (((ux * scl) / 65536) * pct) / 65536;
         ofy = (((uy * scl) / 65536) * pct) / 65536;
         return 1;
      endfunction

      function void note_command(input pfi_pkg::req_payload_type r);
         int a, b;
         longint sx, sy, f_x, f_y;
         bit hit;
         tb_types_pkg::particle_state_type s;
         a = r.particle_a % NPART;
         b = r.particle_b % NPART;
         hit = 0;
         case (r.req_type)
            pfi_pkg::REQ_SET_INIT: begin
               px[a] = r.arg_x; py[a] = r.arg_y; vx[a] = r.arg_vx; vy[a] = r.arg_vy;
            end
            pfi_pkg::REQ_CLR_FORCE: begin
               fx[a] = 0; fy[a] = 0;
            end
            pfi_pkg::REQ_ADD_FORCE: begin
               fx[a] = clamp(longint'(fx[a]) + longint'(r.arg_x));
               fy[a] = clamp(longint'(fy[a]) + longint'(r.arg_y));
            end
            pfi_pkg::REQ_REPEL_PT, pfi_pkg::REQ_ATTRACT_PT, pfi_pkg::REQ_REPEL_PAIR,
            pfi_pkg::REQ_ATTRACT_PAIR: begin
               sx = r.arg_x;
               sy = r.arg_y;
               if (r.req_type == pfi_pkg::REQ_REPEL_PAIR ||
                   r.req_type == pfi_pkg::REQ_ATTRACT_PAIR) begin
                  sx = px[b];
                  sy = py[b];
               end
               hit = radial_push(a, sx, sy, longint'(r.radius), longint'(r.scale), f_x, f_y);
               if (hit) begin
                  if (r.req_type == pfi_pkg::REQ_ATTRACT_PT ||
                      r.req_type == pfi_pkg::REQ_ATTRACT_PAIR) begin
                     f_x = -f_x;
                     f_y = -f_y;
                  end
                  fx[a] = clamp(longint'(fx[a]) + f_x);
                  fy[a] = clamp(longint'(fy[a]) + f_y);
                  if (r.req_type == pfi_pkg::REQ_REPEL_PAIR ||
                      r.req_type == pfi_pkg::REQ_ATTRACT_PAIR) begin
                     fx[b] = clamp(longint'(fx[b]) - f_x);
                     fy[b] = clamp(longint'(fy[b]) - f_y);
                  end
               end
            end
            pfi_pkg::REQ_DAMP: begin
               fx[a] = clamp(longint'(fx[a]) -
                             (longint'(vx[a]) * longint'({15'd0, damping})) / 65536);
               fy[a] = clamp(longint'(fy[a]) -
                             (longint'(vy[a]) * longint'({15'd0, damping})) / 65536);
            end
            pfi_pkg::REQ_UPDATE: begin
               vx[a] = clamp(longint'(vx[a]) + longint'(fx[a]));
               vy[a] = clamp(longint'(vy[a]) + longint'(fy[a]));
               px[a] = clamp(longint'(px[a]) + longint'(vx[a]));
               py[a] = clamp(longint'(py[a]) + longint'(vy[a]));
            end
            default: ;
         endcase
         s.pos_x = px[a]; s.pos_y = py[a]; s.vel_x = vx[a]; s.vel_y = vy[a];
         s.in_range = hit;
         owed.push_back(s);
      endfunction

      task check_result(input tb_types_pkg::particle_state_type got);
         tb_types_pkg::particle_state_type want;
         if (owed.size() == 0) begin
            $display("ERROR at %0t: result with none outstanding", $realtime);
            mismatch_count++;
            return;
         end
         want = owed.pop_front();
         if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
         if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
         if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
         if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
         if (got.in_range !== want.in_range)
            report_mismatch("in_range", got.in_range, want.in_range);
      endtask
   endclass

   particle_scoreboard board = new();

   // Activity counter for the watchdog: any accepted item on any channel counts.
   int quiet_cycles = 0;
   bit long_stall = 0;
   bit stim_done = 0;

   initial begin
      req_ch.valid = 1'b0; req_ch.req_type = '0; req_ch.particle_a = '0;
      req_ch.particle_b = '0; req_ch.arg_x = '0; req_ch.arg_y = '0;
      req_ch.arg_vx = '0; req_ch.arg_vy = '0; req_ch.radius = '0; req_ch.scale = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.damping_coeff = '0;
   end

   // Inputs are sampled at each rising edge; the predictor and checker act on
   // what was accepted at that edge, before any driving process changes it.
   always @(posedge clock) begin
      tb_types_pkg::particle_state_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_command({req_ch.req_type, req_ch.particle_a, req_ch.particle_b,
                                req_ch.arg_x, req_ch.arg_y, req_ch.arg_vx, req_ch.arg_vy,
                                req_ch.radius, req_ch.scale});
         end
         if (csr_ch.valid && csr_ch.ready) board.damping = csr_ch.damping_coeff;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pos_x = rsp_ch.pos_x; got.pos_y = rsp_ch.pos_y;
            got.vel_x = rsp_ch.vel_x; got.vel_y = rsp_ch.vel_y;
            got.in_range = rsp_ch.in_range;
            board.check_result(got);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: a long stretch with no accepted item on any channel means the block hung.
   always @(posedge clock) begin
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("particle_force_integrator_top: mismatch");
         $finish;
      end
   end

   // Receiver: a random stall, sometimes none, before each item, and one long hold-off
   // while the sender keeps offering so that the block backs up.
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall) begin
            rsp_ch.ready <= 1'b0;
            hold = 0;
            while (hold < 600) begin
               @(posedge clock);
               hold++;
            end
            long_stall = 0;
         end
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   // Offers one item and returns at the edge where it was accepted.
   task automatic send_command(input pfi_pkg::req_payload_type r, input bit gaps);
      int wait_cycles;
      wait_cycles = gaps ? $urandom_range(0, 9) : 0;
      if (wait_cycles != 0) begin
         req_ch.valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= r.req_type; req_ch.particle_a <= r.particle_a;
      req_ch.particle_b <= r.particle_b; req_ch.arg_x <= r.arg_x;
      req_ch.arg_y <= r.arg_y; req_ch.arg_vx <= r.arg_vx; req_ch.arg_vy <= r.arg_vy;
      req_ch.radius <= r.radius; req_ch.scale <= r.scale;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
   endtask

   // Waits out every owed result plus the slowest command's latency, with the
   // sender idle, so a register write lands on a quiet block.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_damping(input logic [16:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.damping_coeff <= value;
      @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready)) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $signed(32'h80000000);
         1: return 32'sh7FFFFFFF;
         2: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
         3: return $signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh02000000;
         default: return $signed($urandom());
      endcase
   endfunction

   // Random commands mostly hit a small set of particles so that positions,
   // forces and updates build on one another; pairs draw partners from the same pool.
   function automatic pfi_pkg::req_payload_type random_command(input int pool);
      pfi_pkg::req_payload_type r;
      r.req_type = ($urandom_range(0, 19) == 0)
                 ? 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI))
                 : 4'($urandom_range(pfi_pkg::REQ_SET_INIT, pfi_pkg::REQ_UPDATE));
      r.particle_a = (pool > 0) ? 8'($urandom_range(0, pool - 1)) : 8'($urandom());
      r.particle_b = ($urandom_range(0, 9) == 0) ? r.particle_a
                   : ((pool > 0) ? 8'($urandom_range(0, pool - 1)) : 8'($urandom()));
      r.arg_x = rand_word(); r.arg_y = rand_word();
      r.arg_vx = rand_word(); r.arg_vy = rand_word();
      case ($urandom_range(0, 3))
         0: r.radius = '0;
         1: r.radius = 31'($urandom_range(0, 32'h00FFFFFF));
         2: r.radius = 31'h7FFFFFFF;
         default: r.radius = 31'($urandom());
      endcase
      r.scale = rand_word();
      return r;
   endfunction

   function automatic pfi_pkg::req_payload_type make_cmd(input logic [3:0] kind, input int a,
                                                         input int b, input int x,
                                                         input int y, input int rad,
                                                         input int scl);
      pfi_pkg::req_payload_type r;
      r = '0;
      r.req_type = kind; r.particle_a = 8'(a); r.particle_b = 8'(b);
      r.arg_x = x; r.arg_y = y; r.arg_vx = -x; r.arg_vy = y + 32'sh10000;
      r.radius = 31'(rad); r.scale = scl;
      return r;
   endfunction

   initial begin
      logic [16:0] damp_values[4];
      pfi_pkg::req_payload_type r;
      int pool;
      damp_values = '{17'd0, 17'd65536, 17'h1FFFF, 17'd12345};

      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each command, the field extremes, and the named corner cases.
      send_command(make_cmd(pfi_pkg::REQ_SET_INIT, 1, 0, 32'sh00010000, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_REPEL_PT, 1, 0, 32'sh00010000, 0, 0, 32'sh10000), 0);
      send_command(make_cmd(pfi_pkg::REQ_REPEL_PT, 1, 0, 0, 0, 0, 32'sh00020000), 0);
      send_command(make_cmd(pfi_pkg::REQ_ATTRACT_PT, 1, 0, 0, 0, 32'sh00020000,
                            32'sh10000), 0);
      send_command(make_cmd(pfi_pkg::REQ_ATTRACT_PT, 1, 0, 32'sh00100000, 0, 32'sh10000,
                            32'sh10000), 0);
      send_command(make_cmd(pfi_pkg::REQ_SET_INIT, 2, 0, 32'sh7FFFFFFF, 32'sh80000000,
                            0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_REPEL_PAIR, 1, 2, 0, 0, 32'h7FFFFFFF,
                            32'sh7FFFFFFF), 0);
      send_command(make_cmd(pfi_pkg::REQ_ATTRACT_PAIR, 2, 1, 0, 0, 0, 32'sh80000000), 0);
      send_command(make_cmd(pfi_pkg::REQ_REPEL_PAIR, 3, 3, 0, 0, 0, 32'sh10000), 0);
      send_command(make_cmd(pfi_pkg::REQ_ADD_FORCE, 2, 0, 32'sh7FFFFFFF, 32'sh80000000,
                            0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_ADD_FORCE, 2, 0, 32'sh7FFFFFFF, 32'sh80000000,
                            0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_UPDATE, 2, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_DAMP, 2, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_UPDATE, 1, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_CLR_FORCE, 2, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_UPDATE, 255, 255, 0, 0, 0, 0), 0);
      send_command(make_cmd(REQ_UNKNOWN_HI, 2, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(REQ_UNKNOWN_LO, 1, 0, 0, 0, 0, 0), 0);
      send_command(make_cmd(pfi_pkg::REQ_SET_INIT, 255, 0, 32'sh80000000, 32'sh7FFFFFFF,
                            0, 0), 0);

      // Random phases, one per damping setting; the long receiver hold-off
      // falls in the first one.
      for (int phase = 0; phase < 4; phase++) begin
         drain_block();
         write_damping(damp_values[phase]);
         if (phase == 0) long_stall = 1;
         for (int n = 0; n < 285; n++) begin
            pool = (phase == 3) ? 0 : (phase == 2 ? 16 : 4);
            r = random_command(pool);
            // Stretches without sender gaps are mixed in.
            send_command(r, (n / 40) % 3 != 0);
         end
      end
      req_ch.valid <= 1'b0;

      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && board.owed.size() == 0) begin
         $display("particle_force_integrator_top: match");
      end else begin
         $display("particle_force_integrator_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pfi_pkg.sv
hw/rtl/pfi_if.sv
hw/rtl/pfi_sqrt.sv
hw/rtl/pfi_div.sv
hw/rtl/pfi_dp.sv
hw/rtl/pfi_ctrl.sv
hw/rtl/particle_force_integrator_top.sv
tb/tb_channels.sv
tb/tb.sv
